FILE: src/icrc_pkg.sv
`timescale 1ns / 1ps

package icrc_pkg;

   typedef struct packed {
      logic               running;
      logic signed [23:0] active_ref;
      logic signed [23:0] reactive_ref;
      logic signed [15:0] cos_theta;
      logic signed [15:0] sin_theta;
      logic signed [23:0] bridge_current;
      logic        [22:0] grid_rms;
      logic signed [23:0] bus_voltage;
      logic               counting_up;
   } req_type;

   typedef struct packed {
      logic [15:0] duty_a;
      logic [15:0] duty_b;
      logic        drive_enable;
   } rsp_type;

   // divider handshake toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_STEPS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADTIME_ON   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_BAND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COMP_STEP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_FLOOR    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_CEILING  = 3'd7;

   localparam logic [15:0] RST_PROP_GAIN    = 16'd768;
   localparam logic [15:0] RST_REPEAT_GAIN  = 16'd62259;
   localparam logic [9:0]  RST_LEAD_STEPS   = 10'd15;
   localparam logic [15:0] RST_CURRENT_BAND = 16'd77;
   localparam logic [15:0] RST_COMP_STEP    = 16'd2621;
   localparam logic [15:0] RST_DUTY_FLOOR   = 16'd3277;
   localparam logic [15:0] RST_DUTY_CEILING = 16'd62258;

   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DVD_W = 58;
   localparam int DVS_W = 23;

   localparam logic signed [MUL_B_W-1:0] SQRT2_Q14 = 24'sd23170;

endpackage

FILE: src/inverter_current_repetitive_ctrl.sv
`timescale 1ns / 1ps

// Grid inverter current loop with repetitive control. One request transfer per
// PWM sample gives one response transfer holding both leg duties and the drive
// enable. All products go through one shared registered 40x24 multiplier that
// a small sequencer steps through eight phases; when Vdc is positive the
// quotient ref*32768/Vdc comes from a restoring divider that retires one bit
// per cycle, otherwise the quotient is zero. An item passes through the lead
// wrap (one period subtract per step until the lead index lies in the period),
// the eight multiplier phases, then, when Vdc is positive, the divider start,
// the divide steps and the wait for the done flag, and last the result load,
// which holds while the output is stalled. The next request is taken in the
// cycle after the response is loaded, so one sample is in flight at a time.
// After reset the two period history memories are cleared one entry per cycle,
// and requests stall until the clear is done; configuration writes are taken
// meanwhile.
// Write configuration only while no transfer is in flight.
module inverter_current_repetitive_ctrl #(
   parameter int SAMPLES_PER_PERIOD = 800
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  icrc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output icrc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [icrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [icrc_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam int IDX_W  = $clog2(SAMPLES_PER_PERIOD);
   localparam int SUM_W  = ((IDX_W > 10) ? IDX_W : 10) + 1;
   localparam int VREF_W = 42;
   localparam int DUTY_W = 61;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_LEAD   = 13'b0000000000010,
      ST_MUL1   = 13'b0000000000100,
      ST_MUL2   = 13'b0000000001000,
      ST_MUL3   = 13'b0000000010000,
      ST_MUL4   = 13'b0000000100000,
      ST_MUL5   = 13'b0000001000000,
      ST_MUL6   = 13'b0000010000000,
      ST_MUL7   = 13'b0000100000000,
      ST_MUL8   = 13'b0001000000000,
      ST_DSTART = 13'b0010000000000,
      ST_DIV    = 13'b0100000000000,
      ST_FIN    = 13'b1000000000000
   } state_type;

   // configuration
   logic [15:0] prop_gain_ff, repeat_gain_ff, current_band_ff, comp_step_ff;
   logic [15:0] duty_floor_ff, duty_ceiling_ff;
   logic [9:0]  lead_steps_ff;
   logic        deadtime_on_ff;

   state_type                     state_ff, state_in;
   icrc_pkg::req_type             req_ff, req_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [SUM_W-1:0]              lead_ff, lead_in;
   logic signed [40:0]            acc_ff, acc_in;
   logic signed [31:0]            err_ff, err_in;
   logic signed [32:0]            hsum_ff, hsum_in;
   logic signed [31:0]            rep_ff, rep_in;
   logic signed [40:0]            vp_ff, vp_in;
   logic signed [39:0]            t_ff, t_in;
   logic signed [VREF_W-1:0]      vref_ff, vref_in;
   logic signed [DUTY_W-1:0]      q_ff, q_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   icrc_pkg::rsp_type             rsp_ff, rsp_in;

   logic signed [icrc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [icrc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [icrc_pkg::MUL_P_W-1:0] prod;

   logic                          div_start;
   logic [icrc_pkg::DVD_W-1:0]    div_dividend;
   logic [icrc_pkg::DVD_W-1:0]    div_quotient;
   icrc_pkg::div_stat_type        div_stat;

   logic                          hist_wr;
   logic signed [31:0]            out_hist, err_hist;
   logic                          hist_ready;

   logic signed [40:0]            err_acc;
   logic signed [26:0]            err_sh;
   logic signed [31:0]            err_diff;
   logic signed [33:0]            rep_sh;
   logic signed [28:0]            ff_sh;
   logic [VREF_W-1:0]             vref_mag;
   logic signed [DUTY_W-1:0]      da, db, band, band_neg, step;
   logic signed [DUTY_W-1:0]      cur_w;
   logic                          req_take, rsp_free;

   localparam logic [SUM_W-1:0] PERIOD_SUM = SUM_W'(SAMPLES_PER_PERIOD);

   function automatic logic [15:0] clamp_duty(input logic signed [DUTY_W-1:0] d,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
      logic [15:0] r;
      if (d < $signed({{(DUTY_W-16){1'b0}}, lo})) begin
         r = lo;
      end else if (d > $signed({{(DUTY_W-16){1'b0}}, hi})) begin
         r = hi;
      end else begin
         r = d[15:0];
      end
      return r;
   endfunction

   icrc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   icrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (req_ff.bus_voltage[icrc_pkg::DVS_W-1:0]),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   icrc_hist #(
      .DEPTH (SAMPLES_PER_PERIOD)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (hist_wr),
      .wr_addr   (idx_ff),
      .err_wdata (err_ff),
      .out_wdata (rep_ff),
      .out_raddr (idx_ff),
      .err_raddr (lead_ff[IDX_W-1:0]),
      .out_rdata (out_hist),
      .err_rdata (err_hist),
      .ready     (hist_ready)
   );

   assign req_stall = !(state_ff == ST_IDLE && hist_ready);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign hist_wr   = (state_ff == ST_MUL5);
   assign div_start = (state_ff == ST_DSTART);
   assign vref_mag  = vref_ff[VREF_W-1] ? VREF_W'(-vref_ff) : VREF_W'(vref_ff);
   assign div_dividend = {1'b0, vref_mag, 15'd0};

   // round-half-up scaling of the shared product for the phases that rescale it
   assign err_acc  = acc_ff + $signed(prod[40:0]) + 41'sd8192;
   assign err_sh   = 27'(err_acc >>> 14);
   assign err_diff = 32'(err_sh) - 32'(req_ff.bridge_current);
   assign rep_sh   = 34'(($signed(prod[50:0]) + 51'sd32768) >>> 16);
   assign ff_sh    = 29'(($signed(prod[56:0]) + 57'sd134217728) >>> 28);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = 40'(req_ff.active_ref);
            mul_b = 24'(req_ff.cos_theta);
         end
         ST_MUL2: begin
            mul_a = 40'(req_ff.reactive_ref);
            mul_b = 24'(req_ff.sin_theta);
         end
         ST_MUL3: begin
            mul_a = 40'(hsum_ff);
            mul_b = $signed({8'd0, repeat_gain_ff});
         end
         ST_MUL4: begin
            mul_a = 40'(err_ff);
            mul_b = $signed({8'd0, prop_gain_ff});
         end
         ST_MUL5: begin
            mul_a = 40'(req_ff.cos_theta);
            mul_b = $signed({1'b0, req_ff.grid_rms});
         end
         ST_MUL7: begin
            mul_a = t_ff;
            mul_b = icrc_pkg::SQRT2_Q14;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // duty assembly with optional dead-time compensation
   always_comb begin
      band     = $signed({{(DUTY_W-16){1'b0}}, current_band_ff});
      band_neg = -band;
      step     = $signed({{(DUTY_W-16){1'b0}}, comp_step_ff});
      cur_w    = DUTY_W'(req_ff.bridge_current);
      da       = DUTY_W'(32768) + q_ff;
      db       = DUTY_W'(32768) - q_ff;
      if (deadtime_on_ff) begin
         if (cur_w > band) begin
            if (req_ff.counting_up) begin
               da = da + step;
            end else begin
               db = db - step;
            end
         end
         if (cur_w < band_neg) begin
            if (!req_ff.counting_up) begin
               da = da - step;
            end else begin
               db = db + step;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      lead_in      = lead_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      hsum_in      = hsum_ff;
      rep_in       = rep_ff;
      vp_in        = vp_ff;
      t_in         = t_ff;
      vref_in      = vref_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in   = req_data;
               lead_in  = SUM_W'(idx_ff) + SUM_W'(lead_steps_ff);
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            // wrap the lead index into the period
            if (lead_ff >= PERIOD_SUM) begin
               lead_in = lead_ff - PERIOD_SUM;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = 41'($signed(prod[39:0]));
            hsum_in  = 33'(out_hist) + 33'(err_hist);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            err_in   = req_ff.running ? err_diff : '0;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            if (rep_sh > 34'sd2147483647) begin
               rep_in = 32'sh7fffffff;
            end else if (rep_sh < -34'sd2147483648) begin
               rep_in = 32'sh80000000;
            end else begin
               rep_in = 32'(rep_sh);
            end
            state_in = ST_MUL5;
         end
         ST_MUL5: begin
            vp_in    = 41'(($signed(prod[48:0]) + 49'sd128) >>> 8);
            idx_in   = (idx_ff == IDX_W'(SAMPLES_PER_PERIOD - 1)) ? '0 : idx_ff + 1'b1;
            state_in = ST_MUL6;
         end
         ST_MUL6: begin
            t_in     = $signed(prod[39:0]);
            state_in = ST_MUL7;
         end
         ST_MUL7: begin
            state_in = ST_MUL8;
         end
         ST_MUL8: begin
            vref_in = VREF_W'(vp_ff) + VREF_W'(rep_ff) + VREF_W'(ff_sh);
            if (req_ff.bus_voltage > 24'sd0) begin
               state_in = ST_DSTART;
            end else begin
               q_in     = '0;
               state_in = ST_FIN;
            end
         end
         ST_DSTART: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               q_in = vref_ff[VREF_W-1] ? -$signed({3'b000, div_quotient})
                                        : $signed({3'b000, div_quotient});
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_in.duty_a       = clamp_duty(da, duty_floor_ff, duty_ceiling_ff);
               rsp_in.duty_b       = clamp_duty(db, duty_floor_ff, duty_ceiling_ff);
               rsp_in.drive_enable = req_ff.running;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      lead_ff <= lead_in;
      acc_ff  <= acc_in;
      err_ff  <= err_in;
      hsum_ff <= hsum_in;
      rep_ff  <= rep_in;
      vp_ff   <= vp_in;
      t_ff    <= t_in;
      vref_ff <= vref_in;
      q_ff    <= q_in;
      rsp_ff  <= rsp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= icrc_pkg::RST_PROP_GAIN;
         repeat_gain_ff  <= icrc_pkg::RST_REPEAT_GAIN;
         lead_steps_ff   <= icrc_pkg::RST_LEAD_STEPS;
         deadtime_on_ff  <= 1'b0;
         current_band_ff <= icrc_pkg::RST_CURRENT_BAND;
         comp_step_ff    <= icrc_pkg::RST_COMP_STEP;
         duty_floor_ff   <= icrc_pkg::RST_DUTY_FLOOR;
         duty_ceiling_ff <= icrc_pkg::RST_DUTY_CEILING;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            icrc_pkg::CSR_PROP_GAIN:    prop_gain_ff    <= csr_wdata;
            icrc_pkg::CSR_REPEAT_GAIN:  repeat_gain_ff  <= csr_wdata;
            icrc_pkg::CSR_LEAD_STEPS:   lead_steps_ff   <= csr_wdata[9:0];
            icrc_pkg::CSR_DEADTIME_ON:  deadtime_on_ff  <= csr_wdata[0];
            icrc_pkg::CSR_CURRENT_BAND: current_band_ff <= csr_wdata;
            icrc_pkg::CSR_COMP_STEP:    comp_step_ff    <= csr_wdata;
            icrc_pkg::CSR_DUTY_FLOOR:   duty_floor_ff   <= csr_wdata;
            icrc_pkg::CSR_DUTY_CEILING: duty_ceiling_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/icrc_mul.sv
`timescale 1ns / 1ps

module icrc_mul (
   input  logic                                  clock,
   input  logic signed [icrc_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [icrc_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [icrc_pkg::MUL_P_W-1:0]   prod
);

   logic signed [icrc_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [icrc_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = icrc_pkg::MUL_P_W'(mul_a) * icrc_pkg::MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: src/icrc_div.sv
`timescale 1ns / 1ps

module icrc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [icrc_pkg::DVD_W-1:0]        dividend,
   input  logic [icrc_pkg::DVS_W-1:0]        divisor,
   output logic [icrc_pkg::DVD_W-1:0]        quotient,
   output icrc_pkg::div_stat_type            stat
);

   localparam int CNT_W = $clog2(icrc_pkg::DVD_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [icrc_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [icrc_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [icrc_pkg::DVD_W-1:0]    quo_ff, quo_in;
   logic [icrc_pkg::DVS_W:0]      shifted;
   logic [icrc_pkg::DVS_W+1:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[icrc_pkg::DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(icrc_pkg::DVD_W - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // one restoring step per cycle, quotient bits shift in from the right
         if (!trial[icrc_pkg::DVS_W+1]) begin
            rem_in = trial[icrc_pkg::DVS_W-1:0];
            quo_in = {quo_ff[icrc_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[icrc_pkg::DVS_W-1:0];
            quo_in = {quo_ff[icrc_pkg::DVD_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: src/icrc_hist.sv
`timescale 1ns / 1ps

module icrc_hist #(
   parameter int DEPTH = 800
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [31:0]         err_wdata,
   input  logic signed [31:0]         out_wdata,
   input  logic [$clog2(DEPTH)-1:0]   out_raddr,
   input  logic [$clog2(DEPTH)-1:0]   err_raddr,
   output logic signed [31:0]         out_rdata,
   output logic signed [31:0]         err_rdata,
   output logic                       ready
);

   localparam int AW = $clog2(DEPTH);

   logic signed [31:0] err_mem [DEPTH];
   logic signed [31:0] out_mem [DEPTH];
   logic signed [31:0] out_rd_ff;
   logic signed [31:0] err_rd_ff;
   logic               clr_ff, clr_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         err_mem[clr_addr_ff] <= '0;
         out_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         err_mem[wr_addr] <= err_wdata;
         out_mem[wr_addr] <= out_wdata;
      end
      out_rd_ff <= out_mem[out_raddr];
      err_rd_ff <= err_mem[err_raddr];
   end

   assign out_rdata = out_rd_ff;
   assign err_rdata = err_rd_ff;
   assign ready     = !clr_ff;

endmodule

FILE: src/icrc_checker.sv
`timescale 1ns / 1ps

module icrc_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input icrc_pkg::rsp_type rsp_data
);

   // one sample in flight: the request side stalls right after a transfer
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a sample is in flight");

   // a response never shows up in the cycle right after its request
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("outputs active after reset");

endmodule

bind inverter_current_repetitive_ctrl icrc_props u_icrc_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: bench/icrc_checker.sv
`timescale 1ns / 1ps

module icrc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  icrc_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  icrc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [icrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [icrc_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   localparam int PERIOD = 800;

   logic [15:0] prop_gain, repeat_gain, current_band, comp_step;
   logic [15:0] duty_floor, duty_ceiling;
   logic [9:0]  lead_steps;
   logic        deadtime_on;

   logic signed [31:0] err_hist [PERIOD];
   logic signed [31:0] out_hist [PERIOD];
   int unsigned        slot;

   icrc_pkg::rsp_type duty_queue [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic longint round_shift(longint x, int sh);
      longint y = x + (longint'(1) <<< (sh - 1));
      return y >>> sh;
   endfunction

   function automatic longint sat32(longint x);
      if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (x < -longint'(64'sd2147483648)) return -longint'(64'sd2147483648);
      return x;
   endfunction

   function automatic longint clamp_duty(longint d);
      if (d < longint'(duty_floor)) return longint'(duty_floor);
      if (d > longint'(duty_ceiling)) return longint'(duty_ceiling);
      return d;
   endfunction

   // advances the history memories as the block does
   function icrc_pkg::rsp_type next_duties(icrc_pkg::req_type r);
      longint pref, qref, cs, sn, cur, rms, vdc, err, rep, vref, q, da, db, band;
      int unsigned lidx;
      icrc_pkg::rsp_type res;
      pref = longint'($signed(r.active_ref));
      qref = longint'($signed(r.reactive_ref));
      cs   = longint'($signed(r.cos_theta));
      sn   = longint'($signed(r.sin_theta));
      cur  = longint'($signed(r.bridge_current));
      rms  = longint'(r.grid_rms);
      vdc  = longint'($signed(r.bus_voltage));
      err  = 0;
      q    = 0;
      if (r.running)
         err = sat32(round_shift(pref * cs + qref * sn, 14) - cur);
      lidx = (slot + lead_steps) % PERIOD;
      rep = longint'(out_hist[slot]) + longint'(err_hist[lidx]);
      rep = sat32(round_shift(rep * longint'(repeat_gain), 16));
      out_hist[slot] = rep[31:0];
      err_hist[slot] = err[31:0];
      slot = (slot + 1 >= PERIOD) ? 0 : slot + 1;
      vref = round_shift(err * longint'(prop_gain), 8) + rep
           + round_shift(cs * rms * longint'(icrc_pkg::SQRT2_Q14), 28);
      if (vdc > 0)
         q = (vref * 32768) / vdc;
      da = 32768 + q;
      db = 32768 - q;
      band = longint'(current_band);
      if (deadtime_on) begin
         if (cur > band) begin
            if (r.counting_up) da += longint'(comp_step);
            else               db -= longint'(comp_step);
         end
         if (cur < -band) begin
            if (!r.counting_up) da -= longint'(comp_step);
            else                db += longint'(comp_step);
         end
      end
      da = clamp_duty(da);
      db = clamp_duty(db);
      res.duty_a = da[15:0];
      res.duty_b = db[15:0];
      res.drive_enable = r.running;
      return res;
   endfunction

   always @(posedge clock) begin
      icrc_pkg::rsp_type want;
      if (reset) begin
         prop_gain    = icrc_pkg::RST_PROP_GAIN;
         repeat_gain  = icrc_pkg::RST_REPEAT_GAIN;
         lead_steps   = icrc_pkg::RST_LEAD_STEPS;
         deadtime_on  = 1'b0;
         current_band = icrc_pkg::RST_CURRENT_BAND;
         comp_step    = icrc_pkg::RST_COMP_STEP;
         duty_floor   = icrc_pkg::RST_DUTY_FLOOR;
         duty_ceiling = icrc_pkg::RST_DUTY_CEILING;
         for (int i = 0; i < PERIOD; i++) begin
            err_hist[i] = '0;
            out_hist[i] = '0;
         end
         slot = 0;
         duty_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               icrc_pkg::CSR_PROP_GAIN:    prop_gain    = csr_wdata;
               icrc_pkg::CSR_REPEAT_GAIN:  repeat_gain  = csr_wdata;
               icrc_pkg::CSR_LEAD_STEPS:   lead_steps   = csr_wdata[9:0];
               icrc_pkg::CSR_DEADTIME_ON:  deadtime_on  = csr_wdata[0];
               icrc_pkg::CSR_CURRENT_BAND: current_band = csr_wdata;
               icrc_pkg::CSR_COMP_STEP:    comp_step    = csr_wdata;
               icrc_pkg::CSR_DUTY_FLOOR:   duty_floor   = csr_wdata;
               icrc_pkg::CSR_DUTY_CEILING: duty_ceiling = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (duty_queue.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               want = duty_queue.pop_front();
               if (rsp_data.duty_a !== want.duty_a) begin
                  $error("duty_a expected %0d got %0d", want.duty_a, rsp_data.duty_a);
                  fail_count++;
               end
               if (rsp_data.duty_b !== want.duty_b) begin
                  $error("duty_b expected %0d got %0d", want.duty_b, rsp_data.duty_b);
                  fail_count++;
               end
               if (rsp_data.drive_enable !== want.drive_enable) begin
                  $error("drive_enable expected %0d got %0d",
                         want.drive_enable, rsp_data.drive_enable);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            duty_queue.push_back(next_duties(req_data));
      end
      pending = duty_queue.size();
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASES       = 6;
   localparam int IDLE_LIMIT   = 6000;   // covers the history clear after reset

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   icrc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   icrc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [icrc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [icrc_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   int  fail_count, pending;
   int  idle_cycles = 0;
   bit  calm = 1'b0;   // high while neither side may idle

   // register settings per phase, in index order
   logic [15:0] phase_regs [PHASES][8] = '{
      '{16'd768,   16'd62259, 16'd15,   16'd1, 16'd77,    16'd2621,  16'd3277,  16'd62258},
      '{16'd65535, 16'd65535, 16'd799,  16'd1, 16'd65535, 16'd65535, 16'd0,     16'd65535},
      '{16'd0,     16'd0,     16'd0,    16'd0, 16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd256,   16'd32768, 16'd1023, 16'd1, 16'd0,     16'd1000,  16'd40000, 16'd20000},
      '{16'd3000,  16'd60000, 16'd400,  16'd0, 16'd500,   16'd100,   16'd1000,  16'd64000},
      '{16'd768,   16'd65000, 16'd15,   16'd1, 16'd77,    16'd2621,  16'd3277,  16'd62258}
   };

   inverter_current_repetitive_ctrl uut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   icrc_checker duty_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // stall the response side now and then, except in the calm stretch
   always @(posedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);

   // end the run when no transfer of any kind has happened for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // leave valid high so back-to-back writes follow without a gap
   task automatic write_reg(logic [icrc_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_phase(int p);
      for (int i = 0; i < 8; i++)
         write_reg(icrc_pkg::CSR_IDX_W'(i), phase_regs[p][i]);
      csr_valid <= 1'b0;
   endtask

   // hold off until the block has returned every response, then let it settle
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // hold valid high across back-to-back transfers; drop it only for a gap
   task automatic send(icrc_pkg::req_type item);
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic icrc_pkg::req_type make_item(int unsigned running, int ar, int rr,
                                                   int cs, int sn, int cur, int unsigned rms,
                                                   int vdc, int unsigned up);
      icrc_pkg::req_type r;
      r.running        = running[0];
      r.active_ref     = ar[23:0];
      r.reactive_ref   = rr[23:0];
      r.cos_theta      = cs[15:0];
      r.sin_theta      = sn[15:0];
      r.bridge_current = cur[23:0];
      r.grid_rms       = rms[22:0];
      r.bus_voltage    = vdc[23:0];
      r.counting_up    = up[0];
      return r;
   endfunction

   // mostly plausible operating points with random content, some raw noise
   function automatic icrc_pkg::req_type random_item();
      icrc_pkg::req_type r;
      int trig_c, trig_s, ar, cur, vdc;
      trig_c = int'($urandom_range(32768)) - 16384;
      trig_s = int'($urandom_range(32768)) - 16384;
      if ($urandom_range(99) < 25) begin
         r = icrc_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
         r.cos_theta = trig_c[15:0];
         r.sin_theta = trig_s[15:0];
         return r;
      end
      ar  = int'($urandom_range(40000)) - 20000;
      cur = ((ar * trig_c) >>> 14) + int'($urandom_range(2000)) - 1000;
      case ($urandom_range(9))
         0:       vdc = 0;
         1:       vdc = -int'($urandom_range(8388608, 1));
         2:       vdc = int'($urandom_range(100, 1));
         default: vdc = int'($urandom_range(120000, 80000));
      endcase
      return make_item(($urandom_range(9) != 0), ar, int'($urandom_range(8000)) - 4000,
                       trig_c, trig_s, cur, $urandom_range(62000, 55000), vdc,
                       $urandom_range(1));
   endfunction

   initial begin
      int per_phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      load_phase(0);

      // field extremes, bus voltage corners, both directions around the band
      send(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(make_item(1, 8388607, 8388607, 16384, 16384, -8388608, 8388607, 8388607, 1));
      send(make_item(1, -8388608, -8388608, -16384, -16384, 8388607, 8388607, 1, 0));
      send(make_item(1, 8388607, -8388608, 16384, -16384, 8388607, 0, -8388608, 1));
      send(make_item(1, -8388608, 8388607, -16384, 16384, -8388608, 8388607, 102400, 0));
      send(make_item(0, 8388607, 8388607, 16384, 16384, 8388607, 8388607, 102400, 1));
      send(make_item(1, 1000, 0, 16384, 0, 500, 58880, 0, 1));
      send(make_item(1, 1000, 0, 16384, 0, 500, 58880, -1, 0));
      send(make_item(1, 1000, 0, 16384, 0, 500, 58880, 1, 1));
      send(make_item(1, 0, 0, 0, 0, 78, 0, 102400, 1));
      send(make_item(1, 0, 0, 0, 0, 78, 0, 102400, 0));
      send(make_item(1, 0, 0, 0, 0, 77, 0, 102400, 1));
      send(make_item(1, 0, 0, 0, 0, -78, 0, 102400, 1));
      send(make_item(1, 0, 0, 0, 0, -78, 0, 102400, 0));
      send(make_item(1, 0, 0, 0, 0, -77, 0, 102400, 0));
      send(make_item(1, 20000, 5000, 11585, 11585, -3000, 58880, 102400, 1));
      send(make_item(1, -20000, -5000, -11585, 11585, 3000, 58880, 25600, 0));
      send(make_item(0, 0, 0, 16384, 0, 0, 8388607, 256, 1));
      send(make_item(1, 8388607, 0, 16384, 0, -8388608, 0, 8388607, 0));
      send(make_item(1, -8388608, 0, 16384, 0, 8388607, 0, 8388607, 1));
      req_valid <= 1'b0;

      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         load_phase(p);
         for (int n = 0; n < per_phase; n++) begin
            // one long stretch with no idling on either side
            calm = (p == 2) && (n >= 50) && (n < 250);
            send(random_item());
         end
         req_valid <= 1'b0;
         calm = 1'b0;
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
